>>> hw/rtl/sle_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_pkg
// Shared types and codes for the sequential list engine.
// ----------------------------------------------------------------------------
package sle_pkg;

    localparam int DEPTH_DEF = 1024;

    localparam int OP_W   = 3;
    localparam int POS_W  = 11;
    localparam int VAL_W  = 32;
    localparam int ANS_W  = 11;
    localparam int STAT_W = 2;
    localparam int LEN_W  = 11;

    localparam logic [OP_W-1:0] OP_INSERT     = 3'd0;
    localparam logic [OP_W-1:0] OP_DELETE     = 3'd1;
    localparam logic [OP_W-1:0] OP_FIND       = 3'd2;
    localparam logic [OP_W-1:0] OP_COUNT      = 3'd3;
    localparam logic [OP_W-1:0] OP_DEDUP      = 3'd4;
    localparam logic [OP_W-1:0] OP_DEL_RANGE  = 3'd5;

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_BAD_POS = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;
    localparam logic [STAT_W-1:0] ST_UNUSED  = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_NEXT,
        S_DONE
    } sle_state_t;

    // broadcast from the sequencer to every cell
    typedef struct packed {
        logic             init;   // park the write token on cell 0
        logic             shift;  // rotate the ring one place
        logic             wr;     // write wdata at the token slot
        logic [VAL_W-1:0] wdata;
    } cell_ctrl_t;

endpackage

>>> hw/rtl/sequential_list_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sequential_list_engine
// Ordered list of signed 32-bit values held in a rotating ring of cells.
// ----------------------------------------------------------------------------
// A bad position, a full insert or an unused op answers without a ring turn;
//   insert, delete, find, count and delete range take one full turn of the
//   cell ring, in which one element leaves cell 0 per cycle.
// Dedup runs one ring turn per kept element.
// One item at a time; a new item is taken while the last result still waits.
// Reset (rst_n low, asynchronous) empties the list; element contents stay
//   unset until written, and only entries below the length are ever read.
// ----------------------------------------------------------------------------
module sequential_list_engine #(
    parameter int DEPTH = sle_pkg::DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // op[2:0], position[13:3], value[45:14],
                                   // upper_bound[77:46], zero fill [79:78]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // answer[10:0], status[12:11], length[23:13]
);
    import sle_pkg::*;

    // Each cell hands its element and token to its left neighbour per step;
    // cell 0 wraps round to the last cell, so a full turn restores the order.
    // Writes land at the slot carrying the token, which lets one turn both
    // read the list in order and rewrite it compacted or widened.
    cell_ctrl_t  ctrl;
    logic [31:0] data_w [DEPTH];
    logic        tok_w  [DEPTH];

    logic [ANS_W-1:0]  answer;
    logic [STAT_W-1:0] status;
    logic [LEN_W-1:0]  length;

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            sle_cell #(
                .IS_FIRST (i == 0)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (ctrl),
                .nxt_data (data_w[(i + 1) % DEPTH]),
                .nxt_tok  (tok_w[(i + 1) % DEPTH]),
                .data     (data_w[i]),
                .tok      (tok_w[i])
            );
        end
    endgenerate

    sle_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .op          (s_tdata[2:0]),
        .position    (s_tdata[13:3]),
        .value       (s_tdata[45:14]),
        .upper_bound (s_tdata[77:46]),
        .head        (data_w[0]),
        .ctrl        (ctrl),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .answer      (answer),
        .status      (status),
        .length      (length)
    );

    assign m_tdata = {length, status, answer};

endmodule

>>> hw/rtl/sle_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_cell
// One ring cell: a stored element and a write-token bit.
// ----------------------------------------------------------------------------
module sle_cell #(
    parameter bit IS_FIRST = 1'b0
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  sle_pkg::cell_ctrl_t    ctrl,
    input  logic [31:0]            nxt_data,
    input  logic                   nxt_tok,
    output logic [31:0]            data,
    output logic                   tok
);
    import sle_pkg::*;

    logic [31:0] data_reg;
    logic        tok_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= 1'b0;
        end
        else if (ctrl.init)
        begin
            tok_reg <= IS_FIRST;
        end
        else if (ctrl.shift)
        begin
            // on a write the token stays put: its slot moves on by one
            tok_reg <= ctrl.wr ? tok_reg : nxt_tok;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            data_reg <= (ctrl.wr && nxt_tok) ? ctrl.wdata : nxt_data;
        end
    end

    assign data = data_reg;
    assign tok  = tok_reg;

endmodule

>>> hw/rtl/sle_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_ctrl
// Sequencer: takes an operation, walks the ring once per pass, forms result.
// ----------------------------------------------------------------------------
module sle_ctrl #(
    parameter int DEPTH = sle_pkg::DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [sle_pkg::OP_W-1:0]        op,
    input  logic [sle_pkg::POS_W-1:0]       position,
    input  logic signed [31:0]              value,
    input  logic signed [31:0]              upper_bound,
    input  logic [31:0]                     head,
    output sle_pkg::cell_ctrl_t             ctrl,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [sle_pkg::ANS_W-1:0]       answer,
    output logic [sle_pkg::STAT_W-1:0]      status,
    output logic [sle_pkg::LEN_W-1:0]       length
);
    import sle_pkg::*;

    localparam int IW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

    sle_state_t         state_reg, state_next;
    logic [IW-1:0]      j_reg, j_next;
    logic [CW-1:0]      k_reg, k_next;
    logic [CW-1:0]      n_reg, n_next;
    logic [CW-1:0]      p_reg, p_next;
    logic [CW-1:0]      ans_reg, ans_next;
    logic               found_reg, found_next;
    logic [31:0]        carry_reg, carry_next;
    logic [31:0]        key_reg, key_next;
    logic [OP_W-1:0]    op_reg, op_next;
    logic [CW-1:0]      posm1_reg, posm1_next;
    logic signed [31:0] val_reg, val_next;
    logic signed [31:0] ub_reg, ub_next;
    logic [STAT_W-1:0]  st_reg, st_next;

    logic               ov_reg, ov_next;
    logic [ANS_W-1:0]   oans_reg, oans_next;
    logic [STAT_W-1:0]  ost_reg, ost_next;
    logic [LEN_W-1:0]   olen_reg, olen_next;

    logic [CMPW-1:0] pos_w, n_w;
    logic [CW-1:0]   jw, k_fin;
    logic            in_list, in_range, accept, last, wr;
    logic [31:0]     wdata;

    assign pos_w    = CMPW'(position);
    assign n_w      = CMPW'(n_reg);
    assign jw       = CW'(j_reg);
    assign in_list  = jw < n_reg;
    assign in_range = ($signed(head) >= val_reg) && ($signed(head) <= ub_reg);
    assign last     = (j_reg == IW'(DEPTH - 1));
    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign k_fin    = k_reg + CW'(wr);

    // per-step write decision
    always_comb
    begin
        wr    = 1'b0;
        wdata = head;
        unique case (op_reg)
            OP_INSERT:
            begin
                wr = (jw <= n_reg);
                if (jw < posm1_reg)
                    wdata = head;
                else if (jw == posm1_reg)
                    wdata = val_reg;
                else
                    wdata = carry_reg;
            end
            OP_DELETE:    wr = in_list && (jw != posm1_reg);
            OP_DEL_RANGE: wr = in_list && !in_range;
            OP_DEDUP:     wr = in_list && ((jw <= p_reg) || (head != key_reg));
            default:      wr = 1'b0;
        endcase
        if (state_reg != S_RUN)
            wr = 1'b0;
    end

    always_comb
    begin
        state_next = state_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        n_next     = n_reg;
        p_next     = p_reg;
        ans_next   = ans_reg;
        found_next = found_reg;
        carry_next = carry_reg;
        key_next   = key_reg;
        op_next    = op_reg;
        posm1_next = posm1_reg;
        val_next   = val_reg;
        ub_next    = ub_reg;
        st_next    = st_reg;
        ov_next    = ov_reg;
        oans_next  = oans_reg;
        ost_next   = ost_reg;
        olen_next  = olen_reg;

        ctrl.init  = 1'b0;
        ctrl.shift = 1'b0;
        ctrl.wr    = wr;
        ctrl.wdata = wdata;

        if (out_ready)
            ov_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next    = op;
                    posm1_next = CW'(pos_w - CMPW'(1));
                    val_next   = value;
                    ub_next    = upper_bound;
                    st_next    = ST_OK;
                    ans_next   = '0;
                    found_next = 1'b0;
                    j_next     = '0;
                    k_next     = '0;
                    p_next     = '0;
                    state_next = S_RUN;
                    ctrl.init  = 1'b1;
                    priority if (op == OP_INSERT)
                    begin
                        if (position == '0 || pos_w > n_w + CMPW'(1))
                        begin
                            st_next    = ST_BAD_POS;
                            state_next = S_DONE;
                            ctrl.init  = 1'b0;
                        end
                        else if (n_reg == CW'(DEPTH))
                        begin
                            st_next    = ST_FULL;
                            state_next = S_DONE;
                            ctrl.init  = 1'b0;
                        end
                    end
                    else if (op == OP_DELETE)
                    begin
                        if (position == '0 || pos_w > n_w)
                        begin
                            st_next    = ST_BAD_POS;
                            state_next = S_DONE;
                            ctrl.init  = 1'b0;
                        end
                    end
                    else if (op > OP_DEL_RANGE)
                    begin
                        state_next = S_DONE;
                        ctrl.init  = 1'b0;
                    end
                end
            end
            S_RUN:
            begin
                ctrl.shift = 1'b1;
                carry_next = head;
                k_next     = k_fin;
                j_next     = j_reg + IW'(1);
                if (op_reg == OP_DEDUP && jw == p_reg)
                    key_next = head;
                if (op_reg == OP_FIND && in_list && !found_reg && head == val_reg)
                begin
                    found_next = 1'b1;
                    ans_next   = jw + CW'(1);
                end
                if (op_reg == OP_COUNT && in_list && in_range)
                    ans_next = ans_reg + CW'(1);
                if (last)
                begin
                    j_next     = '0;
                    state_next = S_DONE;
                    if (op_reg != OP_FIND && op_reg != OP_COUNT)
                        n_next = k_fin;
                    if (op_reg == OP_DEDUP && (p_reg + CW'(1)) < k_fin)
                    begin
                        p_next     = p_reg + CW'(1);
                        state_next = S_NEXT;
                    end
                end
            end
            S_NEXT:
            begin
                ctrl.init  = 1'b1;
                j_next     = '0;
                k_next     = '0;
                state_next = S_RUN;
            end
            S_DONE:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next    = 1'b1;
                    oans_next  = ANS_W'(ans_reg);
                    ost_next   = st_reg;
                    olen_next  = LEN_W'(n_reg);
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            n_reg     <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            n_reg     <= n_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        j_reg     <= j_next;
        k_reg     <= k_next;
        p_reg     <= p_next;
        ans_reg   <= ans_next;
        found_reg <= found_next;
        carry_reg <= carry_next;
        key_reg   <= key_next;
        op_reg    <= op_next;
        posm1_reg <= posm1_next;
        val_reg   <= val_next;
        ub_reg    <= ub_next;
        st_reg    <= st_next;
        oans_reg  <= oans_next;
        ost_reg   <= ost_next;
        olen_reg  <= olen_next;
    end

    assign out_valid = ov_reg;
    assign answer    = oans_reg;
    assign status    = ost_reg;
    assign length    = olen_reg;

endmodule

>>> hw/rtl/sle_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_checker
// Port-level checks for the sequential list engine.
// ----------------------------------------------------------------------------
module sle_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);
    import sle_pkg::*;

    // held result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // one item at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item taken while busy");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[12:11] != ST_UNUSED)
        else $error("undefined status code");

    // only insert and delete fail, and they carry no answer
    a_err_answer: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[12:11] != ST_OK |-> m_tdata[10:0] == '0)
        else $error("answer on failed item");

endmodule

bind sequential_list_engine sle_checker u_sle_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> tb/sequential_list_engine_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sequential_list_engine_test
// Self-checking bench for the sequential list engine.
// A shadow list in the bench predicts answer, status and length for every
// item taken. A checker compares each result with the oldest prediction.
// The tests run in turn: directed corner cases, then a long random mix kept
// at short list lengths.
// The sender works in bursts with gaps between them, and the receiver stalls
// on a pattern of its own.
// ----------------------------------------------------------------------------
module sequential_list_engine_test;
    import sle_pkg::*;

    localparam int DEPTH = DEPTH_DEF;
    localparam int HALF_PERIOD = 2;
    localparam int IDLE_LIMIT = 400000;     // covers a dedup at the random length cap
    localparam int LEN_CAP = 48;            // keeps the number of dedup turns small
    localparam int RANDOM_ITEMS = 555;
    localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

    // packed from the top bit down: length, status, answer
    typedef struct packed {
        logic [LEN_W-1:0]  length;
        logic [STAT_W-1:0] status;
        logic [ANS_W-1:0]  answer;
    } list_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [79:0] s_tdata;       // op, position, value, upper_bound, zero fill
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;       // answer, status, length

    logic signed [VAL_W-1:0] shadow_list[$];   // predicted list contents
    list_result_t pending_results[$];          // predictions not yet matched
    int mismatches = 0;
    int burst_left;
    int idle_cycles;

    sequential_list_engine #(.DEPTH(DEPTH)) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        clk = 1'b1;
        #HALF_PERIOD;
        clk = 1'b0;
        #HALF_PERIOD;
    end

    // Works out the result of one item and updates the shadow list.
    function automatic list_result_t predict_list_op(logic [OP_W-1:0] op,
                                                     logic [POS_W-1:0] pos,
                                                     logic signed [VAL_W-1:0] val,
                                                     logic signed [VAL_W-1:0] ub);
        list_result_t r;
        logic signed [VAL_W-1:0] kept[$];
        int n;
        bit seen;
        n = shadow_list.size();
        r = '0;
        r.status = ST_OK;
        case (op)
            OP_INSERT:
            begin
                if (pos < 1 || pos > n + 1)
                    r.status = ST_BAD_POS;
                else if (n >= DEPTH)
                    r.status = ST_FULL;
                else
                    shadow_list.insert(pos - 1, val);
            end
            OP_DELETE:
            begin
                if (pos < 1 || pos > n)
                    r.status = ST_BAD_POS;
                else
                    shadow_list.delete(pos - 1);
            end
            OP_FIND:
            begin
                for (int j = 0; j < n; j++)
                    if (shadow_list[j] == val && r.answer == 0)
                        r.answer = ANS_W'(j + 1);
            end
            OP_COUNT:
            begin
                foreach (shadow_list[j])
                    if (shadow_list[j] >= val && shadow_list[j] <= ub)
                        r.answer++;
            end
            OP_DEDUP:
            begin
                // keep first occurrences in their order
                foreach (shadow_list[j])
                begin
                    seen = 1'b0;
                    foreach (kept[t])
                        if (kept[t] == shadow_list[j])
                            seen = 1'b1;
                    if (!seen)
                        kept.push_back(shadow_list[j]);
                end
                shadow_list = kept;
            end
            OP_DEL_RANGE:
            begin
                foreach (shadow_list[j])
                    if (!(shadow_list[j] >= val && shadow_list[j] <= ub))
                        kept.push_back(shadow_list[j]);
                shadow_list = kept;
            end
            default:
            begin
            end
        endcase
        r.length = LEN_W'(shadow_list.size());
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // Sends one item: bursts of back-to-back items, random gaps in between.
    task automatic send_item(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                             logic signed [VAL_W-1:0] val, logic signed [VAL_W-1:0] ub);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 8);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata <= {2'b00, ub, val, pos, op};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_results.push_back(predict_list_op(op, pos, val, ub));
    endtask

    // Holds the sender off until every prediction has been matched.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Values drawn so that finds hit and dedup finds duplicates.
    function automatic logic signed [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0, 1, 2: return $signed($urandom_range(0, 8)) - 4;
            3, 4:
            begin
                if (shadow_list.size() != 0)
                    return shadow_list[$urandom_range(0, shadow_list.size() - 1)];
                return 0;
            end
            5: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_directed();
        send_item(OP_FIND, 0, 0, 0);                       // find on empty list
        send_item(OP_DELETE, 1, 0, 0);                     // delete from empty list
        send_item(OP_INSERT, 0, 5, 0);                     // position zero
        send_item(OP_INSERT, 2, 5, 0);                     // past the end of empty list
        send_item(OP_INSERT, 1, 0, 0);                     // zero is an ordinary value
        send_item(OP_INSERT, 2, 32'sh7fffffff, 0);         // append largest
        send_item(OP_INSERT, 1, 32'sh80000000, 0);         // prepend smallest
        send_item(OP_INSERT, 2, 7, 0);                     // middle
        send_item(OP_INSERT, 5, 7, 0);                     // duplicate at tail
        send_item(OP_INSERT, 1, 0, 0);                     // duplicate of zero
        send_item(OP_INSERT, 8, 1, 0);                     // one past the end plus one
        send_item(OP_FIND, 11'h7ff, 0, 32'sh55555555);     // first of two zeros
        send_item(OP_FIND, 0, 12345, 0);                   // absent value
        send_item(OP_COUNT, 0, 32'sh80000000, 32'sh7fffffff);
        send_item(OP_COUNT, 0, 7, 7);
        send_item(OP_COUNT, 0, 8, -8);                     // empty range
        send_item(OP_DELETE, 0, 0, 0);                     // position zero
        send_item(OP_DELETE, 7, 0, 0);                     // one past the end
        send_item(OP_DELETE, 3, 0, 0);                     // middle
        send_item(OP_DEDUP, 11'h555, 32'sh2aaaaaaa, -1);
        send_item(OP_SPARE_A, 1, 3, 3);
        send_item(OP_SPARE_B, 11'h7ff, -1, -1);
        send_item(OP_DEL_RANGE, 0, 1, -1);                 // empty range
        send_item(OP_DEL_RANGE, 0, 0, 7);
        send_item(OP_DEL_RANGE, 0, 32'sh80000000, 32'sh7fffffff);
    endtask

    task automatic test_random_mix();
        int n;
        int sel;
        logic [OP_W-1:0] op;
        logic [POS_W-1:0] pos;
        logic signed [VAL_W-1:0] val;
        logic signed [VAL_W-1:0] ub;
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == RANDOM_ITEMS / 2)
                drain_results();
            n = shadow_list.size();
            sel = $urandom_range(0, 99);
            if (n >= LEN_CAP && sel < 40)
                sel = 40;                  // shrink instead of growing further
            if (sel < 40)
                op = OP_INSERT;
            else if (sel < 55)
                op = OP_DELETE;
            else if (sel < 67)
                op = OP_FIND;
            else if (sel < 79)
                op = OP_COUNT;
            else if (sel < 87)
                op = OP_DEDUP;
            else if (sel < 95)
                op = OP_DEL_RANGE;
            else
                op = $urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B;
            if ($urandom_range(0, 9) == 0)
                pos = POS_W'($urandom_range(0, 2047));
            else if (op == OP_INSERT)
                pos = POS_W'($urandom_range(1, n + 1));
            else
                pos = POS_W'($urandom_range(n == 0 ? 0 : 1, n));
            val = pick_value();
            if ((op == OP_COUNT || op == OP_DEL_RANGE) && $urandom_range(0, 7) != 0)
                ub = val + $signed($urandom_range(0, 6));
            else
                ub = pick_value();
            send_item(op, pos, val, ub);
        end
    endtask

    // Receiver: phases of no stall, light random stall and long stalls.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            case (($realtime / 4000.0) > 0 ? (int'($realtime / 4000.0) % 3) : 0)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 3) != 0);
                default: m_tready <= ($urandom_range(0, 15) == 0);
            endcase
        end
    end

    // Result checker.
    always @(posedge clk)
    begin
        list_result_t got;
        list_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            if (pending_results.size() == 0)
                report_mismatch("unexpected result, length", got.length, -1);
            else
            begin
                want = pending_results.pop_front();
                if (got.answer !== want.answer)
                    report_mismatch("answer", got.answer, want.answer);
                if (got.status !== want.status)
                    report_mismatch("status", got.status, want.status);
                if (got.length !== want.length)
                    report_mismatch("length", got.length, want.length);
            end
        end
    end

    // Watchdog on cycles with no handshake on either side.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        burst_left = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_mix();
        drain_results();
        repeat (DEPTH + 10) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/sle_pkg.sv
hw/rtl/sle_cell.sv
hw/rtl/sle_ctrl.sv
hw/rtl/sequential_list_engine.sv
hw/rtl/sle_checker.sv
tb/sequential_list_engine_test.sv
